// ===== src/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the contiguous frame allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int FRAME_W = 20;   // absolute frame number
   localparam int LEN_W   = 15;   // run length / frame counts on the ports
   localparam int CSR_AW  = 3;    // two 32-bit registers
   localparam int CSR_DW  = 32;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // opcodes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_MARK    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // per-frame state codes
   localparam logic [1:0] FS_ALLOC = 2'd0;
   localparam logic [1:0] FS_HEAD  = 2'd2;
   localparam logic [1:0] FS_FREE  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [1:0] STAT_BAD_RUN  = 2'd2;
   localparam logic [1:0] STAT_NOT_POOL = 2'd3;

   // register select (word address bit)
   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   localparam logic [FRAME_W-1:0] BASE_RESET  = '0;
   localparam logic [LEN_W-1:0]   COUNT_RESET = 15'd16384;

   typedef struct packed {
      logic               reinit;   // any register write
      logic [FRAME_W-1:0] base;
      logic [LEN_W-1:0]   count;
   } cfg_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [1:0]         status;
      logic [LEN_W-1:0]   free;
   } res_type;

endpackage

// ===== src/contiguous_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_unit
// First-fit allocator of contiguous frame runs over a two-bit frame map.
// ----------------------------------------------------------------------------
//  - req_*: one transfer carries opcode (allocate, mark, release), start_frame
//    and run_length. rsp_*: one transfer per request with result_frame,
//    status and frames_free.
//  - One request at a time. An allocate runs a first-fit scan that reads
//    one map entry per cycle, then marks the run or reports no space; mark
//    writes the run; release frees frames up to the next free or head frame
//    or the pool end; errors and oversize allocates go straight to the
//    response. The engine returns to idle at the edge that loads the
//    response register and takes the next request from there.
//  - The response sits in an output register; the next request is taken
//    while an earlier response is still stalled. The engine waits only when
//    a new response is ready and the register still holds an untaken one.
//  - Reset and every CSR write start a clear sweep (req_stall high) that
//    frees every map entry and reloads the free count.
//  - CSR: 0x0 pool base frame, 0x4 pool frame count (capped at MAX_FRAMES).
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_unit
   import cfa_pkg::*;
#(
   parameter int MAX_FRAMES = 16384
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [FRAME_W-1:0] req_start_frame,
   input  logic [LEN_W-1:0]   req_run_length,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FRAME_W-1:0] rsp_result_frame,
   output logic [1:0]         rsp_status,
   output logic [LEN_W-1:0]   rsp_frames_free,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int IDX_W = $clog2(MAX_FRAMES);

   cfg_type          cfg;
   res_type          res;
   logic             res_valid;
   logic             res_ready;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [1:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [1:0]       mem_rd_data;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_data_ff,  rsp_data_in;

   cfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cfa_frame_mem #(
      .MAX_FRAMES (MAX_FRAMES),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cfa_engine #(
      .MAX_FRAMES (MAX_FRAMES),
      .IDX_W      (IDX_W)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_start_frame (req_start_frame),
      .req_run_length  (req_run_length),
      .res_ready       (res_ready),
      .res_valid       (res_valid),
      .res             (res),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   // register is free when empty or its transfer completes this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_frame = rsp_data_ff.frame;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_frames_free  = rsp_data_ff.free;

endmodule

// ===== src/cfa_frame_mem.sv =====
// ----------------------------------------------------------------------------
// cfa_frame_mem
// Frame state map: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfa_frame_mem
   import cfa_pkg::*;
#(
   parameter int MAX_FRAMES = 16384,
   parameter int IDX_W      = $clog2(MAX_FRAMES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [1:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [1:0]       rd_data
);

   logic [1:0] state_mem [MAX_FRAMES];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= state_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cfa_csr.sv =====
// ----------------------------------------------------------------------------
// cfa_csr
// APB register file: pool base frame and pool frame count.
// ----------------------------------------------------------------------------
module cfa_csr
   import cfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic               wr_stb;
   logic [FRAME_W-1:0] base_ff,  base_in;
   logic [LEN_W-1:0]   count_ff, count_in;

   // byte address 4*i; low two bits are byte lanes
   assign wr_stb = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      if (wr_stb) begin
         if (csr_paddr[2] == REG_COUNT) begin
            count_in = csr_pwdata[LEN_W-1:0];
         end else begin
            base_in = csr_pwdata[FRAME_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         count_ff <= COUNT_RESET;
      end else begin
         base_ff  <= base_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_COUNT) begin
         csr_prdata = CSR_DW'(count_ff);
      end else begin
         csr_prdata = CSR_DW'(base_ff);
      end
   end

   assign csr_pready  = 1'b1;
   assign cfg.reinit  = wr_stb;
   assign cfg.base    = base_ff;
   assign cfg.count   = count_ff;

endmodule

// ===== src/cfa_engine.sv =====
// ----------------------------------------------------------------------------
// cfa_engine
// Operation sequencer: clear sweep, first-fit scan, run marking and release
// walk over the frame state memory; keeps the free frame count.
// ----------------------------------------------------------------------------
module cfa_engine
   import cfa_pkg::*;
#(
   parameter int MAX_FRAMES = 16384,
   parameter int IDX_W      = $clog2(MAX_FRAMES)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [FRAME_W-1:0] req_start_frame,
   input  logic [LEN_W-1:0]   req_run_length,
   input  logic               res_ready,
   output logic               res_valid,
   output res_type            res,
   output logic               mem_wr_en,
   output logic [IDX_W-1:0]   mem_wr_addr,
   output logic [1:0]         mem_wr_data,
   output logic               mem_rd_en,
   output logic [IDX_W-1:0]   mem_rd_addr,
   input  logic [1:0]         mem_rd_data
);

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_MARK   = 3'd4;
   localparam logic [2:0] S_REL    = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]         state_ff,     state_in;
   logic [1:0]         op_ff,        op_in;
   logic [FRAME_W-1:0] start_ff,     start_in;
   logic [LEN_W-1:0]   len_ff,       len_in;
   logic [CNT_W-1:0]   ptr_ff,       ptr_in;
   logic [IDX_W-1:0]   wr_ptr_ff,    wr_ptr_in;
   logic [IDX_W-1:0]   wr_last_ff,   wr_last_in;
   logic               first_ff,     first_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]   chk_addr_ff,  chk_addr_in;
   logic [CNT_W-1:0]   run_ff,       run_in;
   logic [CNT_W-1:0]   free_ff,      free_in;
   logic [FRAME_W-1:0] frame_ff,     frame_in;
   logic [1:0]         status_ff,    status_in;

   logic [CNT_W-1:0]   eff_cnt;
   logic [FRAME_W-1:0] ofs;
   logic               in_pool;
   logic [IDX_W-1:0]   idx;
   logic [CNT_W-1:0]   room;
   logic [CMP_W-1:0]   len_w;
   logic [CMP_W-1:0]   free_w;
   logic [CNT_W-1:0]   free_inc;
   logic [CNT_W-1:0]   nxt;
   logic [CNT_W-1:0]   run_nxt;
   logic [IDX_W-1:0]   head;

   // effective pool size: register value capped at the map depth
   assign eff_cnt = (CMP_W'(cfg.count) > CMP_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                              : CNT_W'(cfg.count);

   assign ofs     = start_ff - cfg.base;
   assign in_pool = (start_ff >= cfg.base) && (ofs < FRAME_W'(eff_cnt));
   assign idx     = ofs[IDX_W-1:0];
   assign room    = eff_cnt - CNT_W'(idx);
   assign len_w   = CMP_W'(len_ff);
   assign free_w  = CMP_W'(free_ff);
   assign free_inc = (free_ff < eff_cnt) ? free_ff + 1'b1 : free_ff;
   assign run_nxt = (mem_rd_data == FS_FREE) ? run_ff + 1'b1 : '0;
   assign head    = chk_addr_ff - len_ff[IDX_W-1:0] + 1'b1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      wr_last_in   = wr_last_ff;
      first_in     = first_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      run_in       = run_ff;
      free_in      = free_ff;
      frame_in     = frame_ff;
      status_in    = status_ff;
      nxt          = ptr_ff + 1'b1;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_ptr_ff;
      mem_wr_data  = FS_FREE;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ptr_ff[IDX_W-1:0];

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff[IDX_W-1:0];
            free_in     = eff_cnt;
            if (ptr_ff[IDX_W-1:0] == IDX_W'(MAX_FRAMES - 1)) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               start_in = req_start_frame;
               len_in   = req_run_length;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            frame_in  = '0;
            status_in = STAT_OK;
            state_in  = S_DONE;
            case (op_ff)
               OP_ALLOC: begin
                  if (len_ff == '0) begin
                     status_in = STAT_BAD_RUN;
                  end else if (len_w > CMP_W'(eff_cnt)) begin
                     status_in = STAT_NO_SPACE;
                  end else begin
                     ptr_in   = '0;
                     run_in   = '0;
                     state_in = S_SCAN;
                  end
               end
               OP_MARK: begin
                  if (!in_pool) begin
                     status_in = STAT_NOT_POOL;
                  end else if (len_ff == '0 || len_w > CMP_W'(room)) begin
                     status_in = STAT_BAD_RUN;
                  end else begin
                     wr_ptr_in  = idx;
                     wr_last_in = idx + len_ff[IDX_W-1:0] - 1'b1;
                     first_in   = 1'b1;
                     state_in   = S_MARK;
                  end
               end
               OP_RELEASE: begin
                  if (!in_pool) begin
                     status_in = STAT_NOT_POOL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = idx;
                     free_in     = free_inc;
                     nxt         = CNT_W'(idx) + 1'b1;
                     if (nxt < eff_cnt) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = nxt[IDX_W-1:0];
                        ptr_in      = nxt;
                        state_in    = S_REL;
                     end
                  end
               end
               default: begin
                  status_in = STAT_BAD_RUN;
               end
            endcase
         end
         S_SCAN: begin
            // read one entry per cycle; the data is checked in the next cycle
            if (ptr_ff < eff_cnt) begin
               mem_rd_en    = 1'b1;
               ptr_in       = ptr_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_addr_in  = ptr_ff[IDX_W-1:0];
            end
            if (chk_valid_ff) begin
               run_in = run_nxt;
               if (CMP_W'(run_nxt) == len_w) begin
                  chk_valid_in = 1'b0;
                  wr_ptr_in    = head;
                  wr_last_in   = chk_addr_ff;
                  first_in     = 1'b1;
                  frame_in     = cfg.base + FRAME_W'(head);
                  state_in     = S_MARK;
               end
            end else if (ptr_ff >= eff_cnt) begin
               status_in = STAT_NO_SPACE;
               state_in  = S_DONE;
            end
         end
         S_MARK: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = first_ff ? FS_HEAD : FS_ALLOC;
            first_in    = 1'b0;
            if (wr_ptr_ff == wr_last_ff) begin
               free_in  = (free_w > len_w) ? CNT_W'(free_w - len_w) : '0;
               state_in = S_DONE;
            end else begin
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
         end
         S_REL: begin
            // free allocated frames until a free frame, a head or the pool end
            if (mem_rd_data == FS_FREE || mem_rd_data == FS_HEAD) begin
               state_in = S_DONE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ptr_ff[IDX_W-1:0];
               free_in     = free_inc;
               if (nxt < eff_cnt) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = nxt[IDX_W-1:0];
                  ptr_in      = nxt;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            ptr_in   = '0;
         end
      endcase

      // register write re-initializes the pool
      if (cfg.reinit) begin
         state_in     = S_CLEAR;
         ptr_in       = '0;
         chk_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      start_ff    <= start_in;
      len_ff      <= len_in;
      wr_ptr_ff   <= wr_ptr_in;
      wr_last_ff  <= wr_last_in;
      first_ff    <= first_in;
      chk_addr_ff <= chk_addr_in;
      run_ff      <= run_in;
      free_ff     <= free_in;
      frame_ff    <= frame_in;
      status_ff   <= status_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign res_valid  = (state_ff == S_DONE);
   assign res.frame  = frame_ff;
   assign res.status = status_ff;
   assign res.free   = (free_w > CMP_W'(LEN_MAX)) ? LEN_MAX : free_w[LEN_W-1:0];

endmodule
